// File: rtl/core/tcw_pkg.sv
// Shared types, constants and the control program of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;

    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = CHAR_W + ATTR_W;
    localparam int ACTION_W = 3;
    localparam int STEP_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam int ATTR_SHIFT = 4;

    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] NL_CHAR    = 8'h0A;
    localparam logic [CHAR_W-1:0] BS_CHAR    = 8'h08;

    localparam logic [ACTION_W-1:0] ACT_PUT   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_RAW   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_GOTO  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FORE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK = 2'd2;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE  = 4'd0;
    localparam step_t STEP_PUT   = 4'd1;
    localparam step_t STEP_NL    = 4'd2;
    localparam step_t STEP_BS    = 4'd3;
    localparam step_t STEP_GOTO  = 4'd4;
    localparam step_t STEP_NOP   = 4'd5;
    localparam step_t STEP_CLR   = 4'd6;
    localparam step_t STEP_READ  = 4'd7;
    localparam step_t STEP_RWAIT = 4'd8;
    localparam step_t STEP_SINIT = 4'd9;
    localparam step_t STEP_SRD   = 4'd10;
    localparam step_t STEP_SWR   = 4'd11;
    localparam step_t STEP_FILL  = 4'd12;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_WR_CUR,
        MEM_WR_BLANK,
        MEM_WR_COPY,
        MEM_RD_SRC,
        MEM_RD_POS
    } mem_op_t;

    typedef enum logic [2:0] {
        COL_HOLD,
        COL_INC,
        COL_ZERO,
        COL_DEC_SAT,
        COL_LOAD
    } col_op_t;

    typedef enum logic [1:0] {
        ROW_HOLD,
        ROW_INC_SAT,
        ROW_ZERO,
        ROW_LOAD
    } row_op_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ZERO,
        CELL_CAPTURE
    } cell_op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_WRAP,
        COND_ROW_LAST,
        COND_ROWS_ONE,
        COND_COPY_MORE,
        COND_FILL_MORE,
        COND_DISPATCH
    } cond_t;

    typedef struct packed {
        mem_op_t  mem_op;
        col_op_t  col_op;
        row_op_t  row_op;
        ptr_op_t  ptr_op;
        cell_op_t cell_op;
        cond_t    cond;
        step_t    target;
        logic     done;
    } ctrl_t;

    function automatic ctrl_t ucode(input step_t step);
        ctrl_t cw;
        cw = '{MEM_NONE, COL_HOLD, ROW_HOLD, PTR_HOLD, CELL_HOLD, COND_NEVER, STEP_IDLE, 1'b1};
        unique case (step)
            STEP_IDLE:  cw = '{MEM_NONE, COL_HOLD, ROW_HOLD, PTR_HOLD, CELL_ZERO,
                               COND_DISPATCH, STEP_IDLE, 1'b0};
            STEP_PUT:   cw = '{MEM_WR_CUR, COL_INC, ROW_HOLD, PTR_HOLD, CELL_HOLD,
                               COND_WRAP, STEP_NL, 1'b1};
            STEP_NL:    cw = '{MEM_NONE, COL_ZERO, ROW_INC_SAT, PTR_HOLD, CELL_HOLD,
                               COND_ROW_LAST, STEP_SINIT, 1'b1};
            STEP_BS:    cw = '{MEM_NONE, COL_DEC_SAT, ROW_HOLD, PTR_HOLD, CELL_HOLD,
                               COND_NEVER, STEP_IDLE, 1'b1};
            STEP_GOTO:  cw = '{MEM_NONE, COL_LOAD, ROW_LOAD, PTR_HOLD, CELL_HOLD,
                               COND_NEVER, STEP_IDLE, 1'b1};
            STEP_NOP:   cw = '{MEM_NONE, COL_HOLD, ROW_HOLD, PTR_HOLD, CELL_HOLD,
                               COND_NEVER, STEP_IDLE, 1'b1};
            STEP_CLR:   cw = '{MEM_NONE, COL_ZERO, ROW_ZERO, PTR_ZERO, CELL_HOLD,
                               COND_ALWAYS, STEP_FILL, 1'b0};
            STEP_READ:  cw = '{MEM_RD_POS, COL_HOLD, ROW_HOLD, PTR_HOLD, CELL_HOLD,
                               COND_NEVER, STEP_IDLE, 1'b0};
            STEP_RWAIT: cw = '{MEM_RD_POS, COL_HOLD, ROW_HOLD, PTR_HOLD, CELL_CAPTURE,
                               COND_NEVER, STEP_IDLE, 1'b1};
            STEP_SINIT: cw = '{MEM_NONE, COL_HOLD, ROW_HOLD, PTR_ZERO, CELL_HOLD,
                               COND_ROWS_ONE, STEP_FILL, 1'b0};
            STEP_SRD:   cw = '{MEM_RD_SRC, COL_HOLD, ROW_HOLD, PTR_HOLD, CELL_HOLD,
                               COND_NEVER, STEP_IDLE, 1'b0};
            STEP_SWR:   cw = '{MEM_WR_COPY, COL_HOLD, ROW_HOLD, PTR_INC, CELL_HOLD,
                               COND_COPY_MORE, STEP_SRD, 1'b0};
            STEP_FILL:  cw = '{MEM_WR_BLANK, COL_HOLD, ROW_HOLD, PTR_INC, CELL_HOLD,
                               COND_FILL_MORE, STEP_FILL, 1'b1};
            default:    cw = '{MEM_NONE, COL_HOLD, ROW_HOLD, PTR_HOLD, CELL_HOLD,
                               COND_NEVER, STEP_IDLE, 1'b1};
        endcase
        return cw;
    endfunction

endpackage

// File: rtl/core/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = tcw_pkg::CELL_W,
    parameter int DEPTH = tcw_pkg::DEFAULT_COLUMNS * tcw_pkg::DEFAULT_ROWS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/text_console_writer_unit.sv
// Top level of the text console writer: microcoded sequencer, cursor and screen RAM.
`timescale 1ns / 1ps

// Channels: s_* takes one command transaction (put char, put raw symbol, goto,
// clear, read cell); m_* returns exactly one result transaction per command with
// the cursor after the command and, for a read, the cell contents.
// cfg_* writes fore_color, back_color and blink_enable; it is always ready. The user
// must write it only while the unit is idle; the unit itself does not enforce this.
// Steps, from acceptance to result (a step counter walks a control ROM, one step per cycle
// unless a stalled result holds it, limited by the RAM's single write and single read port):
//   put char, raw symbol, backspace, newline off the last row, goto, unused code: its step only
//   put char or raw symbol that wraps to the next line: put step, then newline step
//   read cell: read step, then capture step (registered RAM read)
//   clear: home step, then fill steps (one cell written per cycle)
//   scroll after a newline on the last row, or after a wrap there: an init step, then a
//   read step and a write step per moved cell, and fill steps for the blank bottom row.
// A new command is taken once the previous one has left the sequencer, so one
// result may wait in the output register while the next command runs.
// Reset homes the cursor and loads the default colors; the screen holds garbage
// until cleared or written. A stalled receiver holds the result register; the
// sequencer then holds at the step that ends the command until the register frees up.
module text_console_writer_unit #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
)(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0] s_tdata,   // action[2:0], char_code[10:3], pos_x[17:11], pos_y[22:18]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0] m_tdata    // cursor_col[6:0], cursor_row[11:7], cell_char[19:12],
                                   // cell_attr[27:20]
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int COPY_LAST = (ROWS > 1) ? (ROWS - 1) * COLUMNS - 1 : 0;

    localparam logic [tcw_pkg::COL_W-1:0] LAST_COL  = tcw_pkg::COL_W'(COLUMNS - 1);
    localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW  = tcw_pkg::ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0]         LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0]         LAST_COPY = ADDR_W'(COPY_LAST);

    tcw_pkg::step_t step_reg, step_next;
    tcw_pkg::ctrl_t cw;

    logic [3:0] fore_reg;
    logic [2:0] back_reg;
    logic       blink_reg;

    logic [tcw_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0]          ptr_reg, ptr_next;
    logic [tcw_pkg::CHAR_W-1:0] cell_char_reg, cell_char_next;
    logic [tcw_pkg::ATTR_W-1:0] cell_attr_reg, cell_attr_next;

    logic [tcw_pkg::CHAR_W-1:0] char_reg;
    logic [tcw_pkg::COL_W-1:0]  pos_x_reg;
    logic [tcw_pkg::ROW_W-1:0]  pos_y_reg;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;

    logic [tcw_pkg::ACTION_W-1:0] in_action;
    logic [tcw_pkg::CHAR_W-1:0]   in_char;
    logic                         accept;
    logic                         out_busy;
    logic                         hold;
    logic                         cond_true;
    logic                         emit;
    tcw_pkg::step_t               dispatch;

    logic [tcw_pkg::ATTR_W-1:0] attr;
    logic [tcw_pkg::COL_W-1:0]  sat_x;
    logic [tcw_pkg::ROW_W-1:0]  sat_y;
    logic [ADDR_W-1:0]          cur_addr;
    logic [ADDR_W-1:0]          pos_addr;

    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]    ram_wdata;
    logic [tcw_pkg::CELL_W-1:0]    ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_reg  <= 4'd7;
            back_reg  <= 3'd0;
            blink_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tcw_pkg::CFG_FORE:  fore_reg  <= cfg_data;
                tcw_pkg::CFG_BACK:  back_reg  <= cfg_data[2:0];
                tcw_pkg::CFG_BLINK: blink_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign attr = (tcw_pkg::ATTR_W'({blink_reg, back_reg}) << tcw_pkg::ATTR_SHIFT)
                | tcw_pkg::ATTR_W'(fore_reg);

    assign in_action = s_tdata[2:0];
    assign in_char   = s_tdata[10:3];

    assign cw       = tcw_pkg::ucode(step_reg);
    assign s_tready = (step_reg == tcw_pkg::STEP_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_busy = m_tvalid_reg && !m_tready;
    assign hold     = cw.done && !cond_true && out_busy;

    assign sat_x = ({1'b0, pos_x_reg} >= 8'(COLUMNS)) ? LAST_COL : pos_x_reg;
    assign sat_y = ({1'b0, pos_y_reg} >= 6'(ROWS))    ? LAST_ROW : pos_y_reg;

    assign cur_addr = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign pos_addr = ADDR_W'(sat_y) * ADDR_W'(COLUMNS) + ADDR_W'(sat_x);

    always_comb
    begin
        unique case (in_action)
            tcw_pkg::ACT_PUT:
            begin
                if (in_char == tcw_pkg::NL_CHAR)
                    dispatch = tcw_pkg::STEP_NL;
                else if (in_char == tcw_pkg::BS_CHAR)
                    dispatch = tcw_pkg::STEP_BS;
                else
                    dispatch = tcw_pkg::STEP_PUT;
            end
            tcw_pkg::ACT_RAW:   dispatch = tcw_pkg::STEP_PUT;
            tcw_pkg::ACT_GOTO:  dispatch = tcw_pkg::STEP_GOTO;
            tcw_pkg::ACT_CLEAR: dispatch = tcw_pkg::STEP_CLR;
            tcw_pkg::ACT_READ:  dispatch = tcw_pkg::STEP_READ;
            default:            dispatch = tcw_pkg::STEP_NOP;
        endcase
    end

    always_comb
    begin
        unique case (cw.cond)
            tcw_pkg::COND_NEVER:     cond_true = 1'b0;
            tcw_pkg::COND_ALWAYS:    cond_true = 1'b1;
            tcw_pkg::COND_WRAP:      cond_true = (col_reg == LAST_COL);
            tcw_pkg::COND_ROW_LAST:  cond_true = (row_reg == LAST_ROW);
            tcw_pkg::COND_ROWS_ONE:  cond_true = (ROWS == 1);
            tcw_pkg::COND_COPY_MORE: cond_true = (ptr_reg != LAST_COPY);
            tcw_pkg::COND_FILL_MORE: cond_true = (ptr_reg != LAST_CELL);
            tcw_pkg::COND_DISPATCH:  cond_true = s_tvalid;
            default:                 cond_true = 1'b0;
        endcase
    end

    assign emit = cw.done && !cond_true && !hold;

    always_comb
    begin
        if (hold)
            step_next = step_reg;
        else if (cw.cond == tcw_pkg::COND_DISPATCH)
            step_next = s_tvalid ? dispatch : tcw_pkg::STEP_IDLE;
        else if (cond_true)
            step_next = cw.target;
        else if (cw.done)
            step_next = tcw_pkg::STEP_IDLE;
        else
            step_next = tcw_pkg::STEP_W'(step_reg + 1'b1);
    end

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        ptr_next       = ptr_reg;
        cell_char_next = cell_char_reg;
        cell_attr_next = cell_attr_reg;
        if (!hold)
        begin
            unique case (cw.col_op)
                tcw_pkg::COL_INC:     col_next = col_reg + 1'b1;
                tcw_pkg::COL_ZERO:    col_next = '0;
                tcw_pkg::COL_DEC_SAT: col_next = (col_reg == '0) ? '0 : col_reg - 1'b1;
                tcw_pkg::COL_LOAD:    col_next = sat_x;
                default:              col_next = col_reg;
            endcase
            unique case (cw.row_op)
                tcw_pkg::ROW_INC_SAT: row_next = (row_reg == LAST_ROW) ? row_reg
                                                                       : row_reg + 1'b1;
                tcw_pkg::ROW_ZERO:    row_next = '0;
                tcw_pkg::ROW_LOAD:    row_next = sat_y;
                default:              row_next = row_reg;
            endcase
            unique case (cw.ptr_op)
                tcw_pkg::PTR_ZERO: ptr_next = '0;
                tcw_pkg::PTR_INC:  ptr_next = ptr_reg + 1'b1;
                default:           ptr_next = ptr_reg;
            endcase
            unique case (cw.cell_op)
                tcw_pkg::CELL_ZERO:
                begin
                    cell_char_next = '0;
                    cell_attr_next = '0;
                end
                tcw_pkg::CELL_CAPTURE:
                begin
                    cell_char_next = ram_rdata[tcw_pkg::CHAR_W-1:0];
                    cell_attr_next = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = {attr, tcw_pkg::BLANK_CHAR};
        ram_raddr = ptr_reg;
        unique case (cw.mem_op)
            tcw_pkg::MEM_WR_CUR:
            begin
                ram_we    = !hold;
                ram_waddr = cur_addr;
                ram_wdata = {attr, char_reg};
            end
            tcw_pkg::MEM_WR_BLANK:
            begin
                ram_we = !hold;
            end
            tcw_pkg::MEM_WR_COPY:
            begin
                ram_we    = !hold;
                ram_wdata = ram_rdata;
            end
            tcw_pkg::MEM_RD_SRC: ram_raddr = ptr_reg + ADDR_W'(COLUMNS);
            tcw_pkg::MEM_RD_POS: ram_raddr = pos_addr;
            default: ;
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'd0, cell_attr_next, cell_char_next, row_next, col_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= tcw_pkg::STEP_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        cell_char_reg <= cell_char_next;
        cell_attr_reg <= cell_attr_next;
        m_tdata_reg   <= m_tdata_next;
        if (accept)
        begin
            char_reg  <= in_char;
            pos_x_reg <= s_tdata[17:11];
            pos_y_reg <= s_tdata[22:18];
        end
    end

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/core/tcw_checker.sv
// Port-level assertions for the text console writer and their bind.
`timescale 1ns / 1ps

module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
)(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    localparam logic [7:0] COL_LIMIT = 8'(COLUMNS);
    localparam logic [5:0] ROW_LIMIT = 6'(ROWS);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while previous one still running");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[6:0]} < COL_LIMIT))
        else $error("cursor column out of screen");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[11:7]} < ROW_LIMIT))
        else $error("cursor row out of screen");

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);
